### rtl/rdi_pkg.sv
`timescale 1ns / 1ps
package rdi_pkg;

    localparam int CW     = 32;
    localparam int FB     = 16;
    localparam int SW     = 2 * CW + 3;
    localparam int NW     = SW + FB;
    localparam int QW     = CW;
    localparam int XW     = NW + QW;
    localparam int EW     = 2 * CW + 2;
    localparam int MW     = 31;
    localparam int RSQ_W  = 31;
    localparam int EPS_W  = 16;
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 32;

    localparam logic [MW-1:0] DIST_CAP = {MW{1'b1}};

    localparam logic [1:0] MISS_NONE     = 2'd0;
    localparam logic [1:0] MISS_PARALLEL = 2'd1;
    localparam logic [1:0] MISS_RANGE    = 2'd2;
    localparam logic [1:0] MISS_OUTSIDE  = 2'd3;

    localparam logic [IDX_W-1:0] REG_CENTER_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_CENTER_Z   = 3'd2;
    localparam logic [IDX_W-1:0] REG_NORMAL_X   = 3'd3;
    localparam logic [IDX_W-1:0] REG_NORMAL_Y   = 3'd4;
    localparam logic [IDX_W-1:0] REG_NORMAL_Z   = 3'd5;
    localparam logic [IDX_W-1:0] REG_RADIUS_SQ  = 3'd6;
    localparam logic [IDX_W-1:0] REG_EPSILON    = 3'd7;

    typedef struct packed {
        logic signed [CW-1:0] origin_x;
        logic signed [CW-1:0] origin_y;
        logic signed [CW-1:0] origin_z;
        logic signed [CW-1:0] dir_x;
        logic signed [CW-1:0] dir_y;
        logic signed [CW-1:0] dir_z;
        logic signed [CW-1:0] t_min;
        logic signed [CW-1:0] t_max;
    } t_ray_in;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] hit_distance;
        logic [1:0]           miss_reason;
    } t_hit_out;

    typedef struct packed {
        logic [0:2][CW:0]   w;
        logic [0:2][CW-1:0] d;
        logic [CW-1:0]      tmin;
        logic [CW-1:0]      tmax;
    } t_side;

    typedef struct packed {
        t_side         side;
        logic          par;
        logic          neg;
        logic          ovf;
        logic [NW-1:0] rem;
        logic [SW-1:0] den;
        logic [QW-1:0] q;
    } t_div;

    typedef struct packed {
        t_side         side;
        logic          par;
        logic          rng;
        logic [CW-1:0] t;
    } t_res;

endpackage

### rtl/ray_disk_intersect_core.sv
`timescale 1ns / 1ps
// Ray against disk intersection test, one ray per transaction.
// The disk (center, normal, squared radius, parallel threshold) is loaded
// through the write port i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// load it only while no ray is in flight, as the block does not enforce it.
// Rays enter on i_valid / o_stall and results leave on o_valid / i_stall;
// a transaction moves when valid is high and stall low. Every ray yields
// exactly one result: hit flag, ray parameter t and a miss reason
// (parallel, t out of range, outside radius). The pipeline has nine
// arithmetic stages plus one stage for each of the 32 quotient bits of the
// restoring divider that forms t. Throughput is one ray per cycle while
// o_stall is low; every stage carries its own valid bit. When the receiver
// stalls, the result holds in the output register and the stages behind it
// keep filling bubbles; the input stalls only once every stage holds a ray.
// Synchronous active-low reset clears all valid bits and loads the disk
// registers with center 0, normal (0, 1.0, 0), radius squared 1.0 and
// epsilon 66.
module ray_disk_intersect_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  rdi_pkg::t_ray_in                 i_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output rdi_pkg::t_hit_out                o_data,
    input  logic                             i_cfg_we,
    input  logic [rdi_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [rdi_pkg::CFG_W-1:0]        i_cfg_data
);
    import rdi_pkg::*;

    logic [0:2][CW-1:0] r_cen;
    logic [0:2][CW-1:0] r_nrm;
    logic [RSQ_W-1:0]   r_rsq;
    logic [EPS_W-1:0]   r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cen <= '0;
            r_nrm <= {CW'(0), CW'(1) << FB, CW'(0)};
            r_rsq <= RSQ_W'(1) << FB;
            r_eps <= EPS_W'(66);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_X:  r_cen[0] <= i_cfg_data[CW-1:0];
                REG_CENTER_Y:  r_cen[1] <= i_cfg_data[CW-1:0];
                REG_CENTER_Z:  r_cen[2] <= i_cfg_data[CW-1:0];
                REG_NORMAL_X:  r_nrm[0] <= i_cfg_data[CW-1:0];
                REG_NORMAL_Y:  r_nrm[1] <= i_cfg_data[CW-1:0];
                REG_NORMAL_Z:  r_nrm[2] <= i_cfg_data[CW-1:0];
                REG_RADIUS_SQ: r_rsq <= i_cfg_data[RSQ_W-1:0];
                REG_EPSILON:   r_eps <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    logic r_va, r_vb, r_vc, r_ve, r_vf, r_vg, r_vh, r_vo;
    logic [QW:0] r_dv;
    logic e_a, e_b, e_c, e_e, e_f, e_g, e_h, e_o;
    logic [QW:0] e_d;

    assign e_o = !r_vo || !i_stall;
    assign e_h = !r_vh || e_o;
    assign e_g = !r_vg || e_h;
    assign e_f = !r_vf || e_g;
    assign e_e = !r_ve || e_f;
    assign e_d[QW] = !r_dv[QW] || e_e;
    genvar g;
    for (g = 0; g < QW; g++) begin : g_en
        assign e_d[g] = !r_dv[g] || e_d[g+1];
    end
    assign e_c = !r_vc || e_d[0];
    assign e_b = !r_vb || e_c;
    assign e_a = !r_va || e_b;
    assign o_stall = !e_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_dv <= '0;
            r_ve <= 1'b0; r_vf <= 1'b0; r_vg <= 1'b0; r_vh <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (e_a) r_va <= i_valid;
            if (e_b) r_vb <= r_va;
            if (e_c) r_vc <= r_vb;
            if (e_d[0]) r_dv[0] <= r_vc;
            for (int i = 1; i <= QW; i++) begin
                if (e_d[i]) r_dv[i] <= r_dv[i-1];
            end
            if (e_e) r_ve <= r_dv[QW];
            if (e_f) r_vf <= r_ve;
            if (e_g) r_vg <= r_vf;
            if (e_h) r_vh <= r_vg;
            if (e_o) r_vo <= r_vh;
        end
    end

    // Stage A: plane offset w = center - origin.
    t_side r_sa, n_sa;
    always_comb begin
        n_sa.d[0] = i_data.dir_x;
        n_sa.d[1] = i_data.dir_y;
        n_sa.d[2] = i_data.dir_z;
        n_sa.tmin = i_data.t_min;
        n_sa.tmax = i_data.t_max;
        n_sa.w[0] = (CW+1)'($signed(r_cen[0])) - (CW+1)'(i_data.origin_x);
        n_sa.w[1] = (CW+1)'($signed(r_cen[1])) - (CW+1)'(i_data.origin_y);
        n_sa.w[2] = (CW+1)'($signed(r_cen[2])) - (CW+1)'(i_data.origin_z);
    end
    always_ff @(posedge i_clk) if (e_a) r_sa <= n_sa;

    // Stage B: six products for the two dot products.
    t_side r_sb;
    logic signed [0:2][2*CW-1:0] r_pd;
    logic signed [0:2][2*CW:0]   r_pn;
    always_ff @(posedge i_clk) begin
        if (e_b) begin
            r_sb <= r_sa;
            for (int k = 0; k < 3; k++) begin
                r_pd[k] <= $signed(r_sa.d[k]) * $signed(r_nrm[k]);
                r_pn[k] <= $signed(r_sa.w[k]) * $signed({r_nrm[k][CW-1], r_nrm[k]});
            end
        end
    end

    // Stage C: dot product sums.
    t_side r_sc;
    logic signed [SW-1:0] r_dn, r_num;
    always_ff @(posedge i_clk) begin
        if (e_c) begin
            r_sc  <= r_sb;
            r_dn  <= SW'($signed(r_pd[0])) + SW'($signed(r_pd[1])) + SW'($signed(r_pd[2]));
            r_num <= SW'($signed(r_pn[0])) + SW'($signed(r_pn[1])) + SW'($signed(r_pn[2]));
        end
    end

    // Stage D: magnitudes, parallel test and quotient overflow test.
    t_div r_ds [0:QW];
    t_div n_ds [0:QW];
    logic [SW-1:0] adn, anum;
    logic [NW-1:0] nmag;
    always_comb begin
        adn  = r_dn[SW-1] ? SW'(-r_dn) : SW'(r_dn);
        anum = r_num[SW-1] ? SW'(-r_num) : SW'(r_num);
        nmag = {anum, {FB{1'b0}}};
        n_ds[0].side = r_sc;
        n_ds[0].par  = adn <= (SW'(r_eps) << FB);
        n_ds[0].neg  = r_dn[SW-1] != r_num[SW-1];
        n_ds[0].ovf  = XW'(nmag) >= (XW'(adn) << QW);
        n_ds[0].rem  = nmag;
        n_ds[0].den  = adn;
        n_ds[0].q    = '0;
    end
    always_ff @(posedge i_clk) if (e_d[0]) r_ds[0] <= n_ds[0];

    // Restoring divider, one quotient bit per stage, most significant first.
    for (g = 1; g <= QW; g++) begin : g_div
        localparam int B = QW - g;
        logic [XW-1:0] dsh;
        assign dsh = XW'(r_ds[g-1].den) << B;
        always_comb begin
            n_ds[g] = r_ds[g-1];
            if (XW'(r_ds[g-1].rem) >= dsh) begin
                n_ds[g].rem  = r_ds[g-1].rem - NW'(dsh);
                n_ds[g].q[B] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) if (e_d[g]) r_ds[g] <= n_ds[g];
    end

    // Stage E: signed, saturated t and the range test.
    t_res r_re, n_re;
    logic [QW-1:0] qv;
    logic signed [CW-1:0] tv;
    always_comb begin
        qv = r_ds[QW].q;
        if (r_ds[QW].neg) begin
            if (r_ds[QW].ovf || qv > (QW'(1) << (CW-1))) tv = {1'b1, {(CW-1){1'b0}}};
            else tv = CW'(-qv);
        end else begin
            if (r_ds[QW].ovf || qv[QW-1]) tv = {1'b0, {(CW-1){1'b1}}};
            else tv = CW'(qv);
        end
        n_re.side = r_ds[QW].side;
        n_re.par  = r_ds[QW].par;
        n_re.rng  = (tv < $signed(r_ds[QW].side.tmin)) || (tv > $signed(r_ds[QW].side.tmax));
        n_re.t    = r_ds[QW].par ? '0 : tv;
    end
    always_ff @(posedge i_clk) if (e_e) r_re <= n_re;

    // Stage F: t times direction.
    t_res r_rf;
    logic signed [0:2][2*CW-1:0] r_tp;
    always_ff @(posedge i_clk) begin
        if (e_f) begin
            r_rf <= r_re;
            for (int k = 0; k < 3; k++) begin
                r_tp[k] <= $signed(r_re.t) * $signed(r_re.side.d[k]);
            end
        end
    end

    // Stage G: per-axis distance magnitude, truncated and capped.
    t_res r_rg;
    logic [0:2][MW-1:0] r_mv, n_mv;
    logic signed [EW-1:0] ev [0:2];
    logic [EW-1:0] em [0:2];
    logic [EW-1:0] es [0:2];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ev[k] = (EW'($signed(r_rf.side.w[k])) <<< FB) - EW'($signed(r_tp[k]));
            em[k] = ev[k][EW-1] ? EW'(-ev[k]) : EW'(ev[k]);
            es[k] = em[k] >> FB;
            n_mv[k] = (es[k] > EW'(DIST_CAP)) ? DIST_CAP : es[k][MW-1:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (e_g) begin
            r_rg <= r_rf;
            r_mv <= n_mv;
        end
    end

    // Stage H: squares.
    t_res r_rh;
    logic [0:2][2*MW-1:0] r_sq;
    always_ff @(posedge i_clk) begin
        if (e_h) begin
            r_rh <= r_rg;
            for (int k = 0; k < 3; k++) r_sq[k] <= r_mv[k] * r_mv[k];
        end
    end

    // Output stage: sum of squares against the radius and result selection.
    t_hit_out r_out, n_out;
    logic [2*MW+1:0] ssum;
    logic            in_disk;
    always_comb begin
        ssum = (2*MW+2)'(r_sq[0]) + (2*MW+2)'(r_sq[1]) + (2*MW+2)'(r_sq[2]);
        in_disk = ssum < ((2*MW+2)'(r_rsq) << FB);
        n_out.hit_distance = r_rh.t;
        if (r_rh.par) begin
            n_out.hit = 1'b0;
            n_out.miss_reason = MISS_PARALLEL;
        end else if (r_rh.rng) begin
            n_out.hit = 1'b0;
            n_out.miss_reason = MISS_RANGE;
        end else if (in_disk) begin
            n_out.hit = 1'b1;
            n_out.miss_reason = MISS_NONE;
        end else begin
            n_out.hit = 1'b0;
            n_out.miss_reason = MISS_OUTSIDE;
        end
    end
    always_ff @(posedge i_clk) if (e_o) r_out <= n_out;

    assign o_valid = r_vo;
    assign o_data  = r_out;

endmodule

### dv/ray_disk_intersect_core_tb.sv
`timescale 1ns / 1ps
module ray_disk_intersect_core_tb;
    import rdi_pkg::*;

    localparam int ONE       = 1 << FB;
    localparam int MAX_CYC   = 400000;
    localparam int DRAIN_CYC = 60;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    t_ray_in             i_data = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    t_hit_out            o_data;
    logic                i_cfg_we = 1'b0;
    logic [IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    ray_disk_intersect_core u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    logic signed [CW-1:0] disk_c[3];
    logic signed [CW-1:0] disk_n[3];
    logic [RSQ_W-1:0]     disk_rsq;
    logic [EPS_W-1:0]     disk_eps;

    t_ray_in  ray_q[$];
    t_hit_out hit_q[$];
    bit       in_taken;
    bit       hold_rays;
    int       send_idle;
    int       recv_idle;
    int       errors;
    int       cycles;
    int       reason_cnt[4];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_hit_out predict_hit(t_ray_in r);
        logic signed [127:0] o[3], d[3], w[3], n[3];
        logic signed [127:0] dn, adn, num, anum, q, t, e, m, lim;
        logic [127:0]        sum;
        t_hit_out            res;
        o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
        d[0] = r.dir_x;    d[1] = r.dir_y;    d[2] = r.dir_z;
        for (int k = 0; k < 3; k++) begin
            n[k] = disk_n[k];
            w[k] = $signed(disk_c[k]) - o[k];
        end
        res = '0;
        dn = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        adn = (dn < 0) ? -dn : dn;
        if (adn <= ($signed({112'd0, disk_eps}) <<< FB)) begin
            res.miss_reason = MISS_PARALLEL;
            return res;
        end
        num = w[0] * n[0] + w[1] * n[1] + w[2] * n[2];
        anum = (num < 0) ? -num : num;
        q = (anum <<< FB) / adn;
        lim = 128'sd2147483647;
        if ((num < 0) != (dn < 0))
            t = (q > lim + 1) ? -(lim + 1) : -q;
        else
            t = (q > lim) ? lim : q;
        res.hit_distance = t[CW-1:0];
        if (t < $signed(r.t_min) || t > $signed(r.t_max)) begin
            res.miss_reason = MISS_RANGE;
            return res;
        end
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            e = (w[k] <<< FB) - t * d[k];
            m = ((e < 0) ? -e : e) >>> FB;
            if (m > lim) m = lim;
            sum = sum + m * m;
        end
        if (sum < ({97'd0, disk_rsq} << FB)) begin
            res.hit = 1'b1;
            res.miss_reason = MISS_NONE;
        end else begin
            res.miss_reason = MISS_OUTSIDE;
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_hit_out want;
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (hit_q.size() == 0) begin
                report_mismatch("unexpected transaction", o_data, 0);
            end else begin
                want = hit_q.pop_front();
                reason_cnt[want.miss_reason]++;
                if (o_data.hit !== want.hit)
                    report_mismatch("hit", o_data.hit, want.hit);
                if (o_data.hit_distance !== want.hit_distance)
                    report_mismatch("hit_distance", o_data.hit_distance, want.hit_distance);
                if (o_data.miss_reason !== want.miss_reason)
                    report_mismatch("miss_reason", o_data.miss_reason, want.miss_reason);
            end
        end
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) hit_q.push_back(predict_hit(i_data));
    end

    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (i_rst_n && ray_q.size() > 0 && !hold_rays
                    && $urandom_range(99) >= send_idle) begin
                i_valid <= 1'b1;
                i_data <= ray_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= i_rst_n && ($urandom_range(99) < recv_idle);
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        case (idx)
            REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: disk_c[idx] = val;
            REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z: disk_n[idx - REG_NORMAL_X] = val;
            REG_RADIUS_SQ: disk_rsq = val[RSQ_W-1:0];
            default: disk_eps = val[EPS_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_disk(int cx, int cy, int cz, int nx, int ny, int nz,
                            logic [CFG_W-1:0] rsq, logic [CFG_W-1:0] eps);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_NORMAL_X, nx);
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_RADIUS_SQ, rsq);
        write_reg(REG_EPSILON, eps);
    endtask

    function automatic t_ray_in mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                       int tmin, int tmax);
        t_ray_in r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx;    r.dir_y = dy;    r.dir_z = dz;
        r.t_min = tmin;  r.t_max = tmax;
        return r;
    endfunction

    function automatic int small_val(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    function automatic t_ray_in random_ray();
        t_ray_in r;
        int      tgt[3], org[3];
        int      sel;
        sel = $urandom_range(99);
        if (sel < 20) begin
            r = {$urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom};
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            org[k] = disk_c[k] + small_val(16 * ONE);
            tgt[k] = disk_c[k] + small_val(2 * ONE);
        end
        r = mk_ray(org[0], org[1], org[2], tgt[0] - org[0], tgt[1] - org[1],
                   tgt[2] - org[2], -$signed($urandom_range(2 * ONE)),
                   $urandom_range(4 * ONE, 32'h7fffffff));
        if (sel < 27) begin
            r.dir_x = small_val(3); r.dir_y = small_val(3); r.dir_z = small_val(3);
        end else if (sel < 35) begin
            r.t_min = small_val(3 * ONE);
            r.t_max = small_val(3 * ONE);
        end
        return r;
    endfunction

    task automatic drain();
        while (ray_q.size() > 0 || i_valid || hit_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic random_phase(int count, int mode);
        send_idle = (mode == 0) ? 6 : (mode == 1) ? 55 : 0;
        recv_idle = (mode == 0) ? 55 : (mode == 1) ? 6 : 0;
        for (int i = 0; i < count; i++) ray_q.push_back(random_ray());
        drain();
    endtask

    initial begin
        disk_c = '{0, 0, 0};
        disk_n = '{0, ONE, 0};
        disk_rsq = ONE;
        disk_eps = 66;
        send_idle = 6;
        recv_idle = 55;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        ray_q.push_back(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0, 0, 32'h7fffffff));
        ray_q.push_back(mk_ray(2 * ONE, 5 * ONE, 0, 0, -ONE, 0, 0, 32'h7fffffff));
        ray_q.push_back(mk_ray(ONE / 2, 5 * ONE, 0, 0, -ONE, 0, 0, 32'h7fffffff));
        ray_q.push_back(mk_ray(0, 5 * ONE, 0, ONE, 0, 0, 0, 32'h7fffffff));
        ray_q.push_back(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0, 10 * ONE, 20 * ONE));
        ray_q.push_back(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0, 20 * ONE, 10 * ONE));
        ray_q.push_back(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0, 5 * ONE, 5 * ONE));
        ray_q.push_back(mk_ray(0, -5 * ONE, 0, 0, -ONE, 0,
                               32'h80000000, 32'h7fffffff));
        ray_q.push_back(mk_ray(0, 32'h80000000, 0, 0, 67, 0, 0, 32'h7fffffff));
        ray_q.push_back(mk_ray(0, 32'h80000000, 0, 0, -67, 0,
                               32'h80000000, 32'h7fffffff));
        ray_q.push_back(mk_ray(0, 5 * ONE, 0, 0, 66, 0, 0, 32'h7fffffff));
        ray_q.push_back(mk_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h80000000, 32'h7fffffff));
        ray_q.push_back(mk_ray(32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h7fffffff));
        ray_q.push_back(mk_ray(0, 0, 0, 0, ONE, 0, 32'h80000000, 32'h7fffffff));
        drain();

        set_disk(0, 0, 0, 0, 0, 0, ONE, 0);
        ray_q.push_back(mk_ray(0, 5 * ONE, 0, 0, -ONE, 0, 0, 32'h7fffffff));
        ray_q.push_back(mk_ray(3, -7, 1, -ONE, ONE, 5, 32'h80000000, 32'h7fffffff));
        drain();

        set_disk(ONE, 2 * ONE, -ONE, ONE / 3, ONE, -ONE / 2, 4 * ONE, 66);
        random_phase(75, 0);

        set_disk(-3 * ONE, ONE, 7 * ONE, 0, 0, -ONE, 0, 65535);
        random_phase(60, 0);

        set_disk(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
        random_phase(40, 1);

        set_disk(small_val(8 * ONE), small_val(8 * ONE), small_val(8 * ONE),
                 $urandom, $urandom, $urandom, $urandom, $urandom);
        random_phase(40, 1);

        set_disk(small_val(8 * ONE), small_val(8 * ONE), small_val(8 * ONE),
                 small_val(2 * ONE), small_val(2 * ONE), small_val(2 * ONE),
                 $urandom_range(9 * ONE), $urandom_range(200));
        send_idle = 0;
        recv_idle = 0;
        for (int i = 0; i < 40; i++) ray_q.push_back(random_ray());
        while (ray_q.size() > 0) @(posedge i_clk);
        hold_rays = 1'b1;
        while (i_valid || hit_q.size() > 0) @(posedge i_clk);
        hold_rays = 1'b0;
        for (int i = 0; i < 40; i++) ray_q.push_back(random_ray());
        drain();

        set_disk(ONE, ONE, ONE, ONE, ONE, ONE, 16 * ONE, 66);
        random_phase(75, 2);

        set_disk(-ONE, 0, ONE, -ONE, 0, 0, 2 * ONE, 1000);
        random_phase(75, 2);

        $display("Rays checked by outcome: %0d hit, %0d parallel, %0d out of range, %0d outside",
                 reason_cnt[MISS_NONE], reason_cnt[MISS_PARALLEL],
                 reason_cnt[MISS_RANGE], reason_cnt[MISS_OUTSIDE]);
        $display("Disk settings covered zero normal, extreme registers and all idle patterns.");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
